// ===== rtl/bdq_pkg.sv =====
// shared types and codes for the bounded deque with value delete
package bdq_pkg;

  localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
  localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
  localparam logic [3:0] ACT_POP_FRONT  = 4'd2;
  localparam logic [3:0] ACT_POP_BACK   = 4'd3;
  localparam logic [3:0] ACT_DELETE     = 4'd4;
  localparam logic [3:0] ACT_READ_ALL   = 4'd5;
  localparam logic [3:0] ACT_READ_FIRST = 4'd6;
  localparam logic [3:0] ACT_READ_LAST  = 4'd7;
  localparam logic [3:0] ACT_CLEAR      = 4'd8;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic latch;
    logic walk_init;
    logic walk_step;
    logic update;
    logic emit_ack;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic [3:0] action;
    logic       walk_zero;
    logic       walk_last;
  } sts_t;

endpackage

// ===== rtl/bdq_ram.sv =====
// generic single write port ram with registered read
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bdq_ctrl.sv =====
// command sequencer for the deque
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.action) inside
          bdq_pkg::ACT_READ_ALL, bdq_pkg::ACT_READ_FIRST, bdq_pkg::ACT_READ_LAST: begin
            if (sts.walk_zero) begin
              cmd.emit_empty = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          bdq_pkg::ACT_DELETE: begin
            if (sts.walk_zero) begin
              cmd.emit_ack = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          default: begin
            cmd.update   = 1'b1;
            cmd.emit_ack = 1'b1;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          cmd.emit_ack = (sts.action == bdq_pkg::ACT_DELETE);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bdq_datapath.sv =====
// deque storage, pointers, walk counters and result registers
module bdq_datapath #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bdq_pkg::cmd_t      cmd,
  output bdq_pkg::sts_t      sts,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_count,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_entry_value,
  output logic               out_last_of_run,
  output logic [5:0]         out_length,
  output logic               out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > 6) ? CW : 6;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] pos_r, end_r, kept_r, kept_nxt;
  logic [3:0]    act_r;
  logic [31:0]   val_r;
  logic          rd_pend_r;
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [31:0]   out_value_r;
  logic          out_last_r;
  logic [5:0]    out_length_r;
  logic          out_ovf_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [CW-1:0] walk_start, walk_n;
  logic          is_del, is_push, full, issue, walk_last, del_keep;
  logic          emit_entry, emit_any, ovf;
  logic [AW-1:0] front_dec;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(p);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  bdq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_del    = (act_r == bdq_pkg::ACT_DELETE);
  assign is_push   = (act_r == bdq_pkg::ACT_PUSH_FRONT) || (act_r == bdq_pkg::ACT_PUSH_BACK);
  assign full      = (count_r == CW'(DEPTH));
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign raddr     = slot_of(front_r, pos_r);
  assign issue     = cmd.walk_step && (pos_r != end_r);
  assign walk_last = rd_pend_r && (pos_r == end_r);
  assign del_keep  = rd_pend_r && is_del && (rdata != val_r);

  always_comb begin
    walk_start = '0;
    walk_n     = count_r;
    unique case (act_r)
      bdq_pkg::ACT_READ_FIRST: begin
        walk_n = cnt_r;
      end
      bdq_pkg::ACT_READ_LAST: begin
        walk_start = count_r - cnt_r;
        walk_n     = cnt_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    kept_nxt  = kept_r;
    we        = 1'b0;
    waddr     = slot_of(front_r, kept_r);
    wdata     = val_r;
    if (cmd.update) begin
      unique case (act_r)
        bdq_pkg::ACT_PUSH_FRONT: begin
          if (!full) begin
            we        = 1'b1;
            waddr     = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::ACT_PUSH_BACK: begin
          if (!full) begin
            we        = 1'b1;
            waddr     = slot_of(front_r, count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::ACT_POP_FRONT: begin
          if (count_r != '0) begin
            front_nxt = slot_of(front_r, CW'(1));
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::ACT_POP_BACK: begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::ACT_CLEAR: begin
          front_nxt = '0;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
    if (cmd.walk_step && del_keep) begin
      we       = 1'b1;
      waddr    = slot_of(front_r, kept_r);
      wdata    = rdata;
      kept_nxt = kept_r + 1'b1;
    end
    if (cmd.walk_step && is_del && walk_last) begin
      count_nxt = kept_nxt;
    end
  end

  assign emit_entry = cmd.walk_step && rd_pend_r && !is_del;
  assign emit_any   = cmd.emit_ack || cmd.emit_empty || emit_entry;
  assign ovf        = cmd.emit_ack && cmd.update && is_push && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= issue;
      out_valid_r <= emit_any;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      val_r <= in_value;
      cnt_r <= (XW'(in_count) > XW'(count_r)) ? count_r : CW'(in_count);
    end
    if (cmd.walk_init) begin
      pos_r  <= walk_start;
      end_r  <= walk_start + walk_n;
      kept_r <= '0;
    end else begin
      if (issue) begin
        pos_r <= pos_r + 1'b1;
      end
      kept_r <= kept_nxt;
    end
    if (emit_any) begin
      out_kind_r   <= emit_entry ? bdq_pkg::KIND_ENTRY :
                      (cmd.emit_empty ? bdq_pkg::KIND_EMPTY : bdq_pkg::KIND_ACK);
      out_value_r  <= emit_entry ? rdata : 32'd0;
      out_last_r   <= emit_entry ? (pos_r == end_r) : 1'b1;
      out_length_r <= 6'(count_nxt);
      out_ovf_r    <= ovf;
    end
  end

  assign sts.action    = act_r;
  assign sts.walk_zero = (walk_n == '0);
  assign sts.walk_last = walk_last;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_entry_value = out_value_r;
  assign out_last_of_run = out_last_r;
  assign out_length      = out_length_r;
  assign out_overflow    = out_ovf_r;

endmodule

// ===== rtl/bounded_deque_with_value_delete_unit.sv =====
// top level of the bounded deque with value delete
//
// a command transaction is taken at a rising edge with start high and busy low;
// in_action selects push front/back, pop front/back, delete by value, read all,
// read first, read last or clear, in_value and in_count give its operands
// results leave on the out_ ports, each for one cycle marked by out_valid;
// the receiver cannot stall, so every result is taken as it appears
// non-read commands give one acknowledgement with the new length, and out_overflow
// set when a push met a full deque; reads give one entry per cycle, front to
// back, out_last_of_run on the final one, or one empty marker when nothing is read
// push, pop, clear, unused codes, an empty read and a delete on an empty
// deque give their result straight from the dispatch state;
// a read of n entries goes from the dispatch state into the walk, reads each
// entry through the registered ram read port and shows one entry per cycle;
// delete walks all stored entries, one per cycle through the ram read port,
// and acknowledges with the new length when the walk ends
// busy drops at the same edge at which the final result shows
// reset clears the length and front pointer; entry storage is not cleared
module bounded_deque_with_value_delete_unit #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_count,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_entry_value,
  output logic               out_last_of_run,
  output logic [5:0]         out_length,
  output logic               out_overflow
);

  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bdq_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_entry_value (out_entry_value),
    .out_last_of_run (out_last_of_run),
    .out_length      (out_length),
    .out_overflow    (out_overflow)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the bounded deque with value delete unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_value;
    logic        last_of_run;
    logic [5:0]  length;
    logic        overflow;
  } deque_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [3:0]         in_action;
  logic signed [31:0] in_value;
  logic [5:0]         in_count;
  logic               out_valid;
  logic [1:0]         out_kind;
  logic signed [31:0] out_entry_value;
  logic               out_last_of_run;
  logic [5:0]         out_length;
  logic               out_overflow;

  deque_result_t pending_results[$];
  logic [31:0]   shadow_slots[DEPTH];
  int unsigned   shadow_head;
  int unsigned   shadow_fill;
  int            mismatch_count;

  bounded_deque_with_value_delete_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_value(in_value),
    .in_count(in_count),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_entry_value(out_entry_value),
    .out_last_of_run(out_last_of_run),
    .out_length(out_length),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[bounded_deque_with_value_delete_unit] ERROR");
    $finish;
  end

  function automatic int unsigned slot_at(int unsigned pos);
    return (shadow_head + pos) % DEPTH;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [31:0] val, logic last,
                                       logic ovf);
    deque_result_t r;
    r.kind        = kind;
    r.entry_value = val;
    r.last_of_run = last;
    r.length      = shadow_fill[5:0];
    r.overflow    = ovf;
    pending_results.push_back(r);
  endfunction

  function automatic void queue_reads(int unsigned first, int unsigned n);
    if (n == 0) begin
      queue_result(bdq_pkg::KIND_EMPTY, 32'd0, 1'b1, 1'b0);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        queue_result(bdq_pkg::KIND_ENTRY, shadow_slots[slot_at(first + i)], (i + 1 == n),
                     1'b0);
      end
    end
  endfunction

  function automatic void apply_command(logic [3:0] act, logic [31:0] val, logic [5:0] cnt);
    int unsigned n;
    int unsigned kept;
    int unsigned total;
    logic [31:0] v;
    logic        ovf;
    logic        is_read;
    ovf     = 1'b0;
    is_read = 1'b0;
    n       = (cnt > shadow_fill) ? shadow_fill : cnt;
    case (act)
      bdq_pkg::ACT_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          ovf = 1'b1;
        end else begin
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_slots[shadow_head] = val;
          shadow_fill++;
        end
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          ovf = 1'b1;
        end else begin
          shadow_slots[slot_at(shadow_fill)] = val;
          shadow_fill++;
        end
      end
      bdq_pkg::ACT_POP_FRONT: begin
        if (shadow_fill > 0) begin
          shadow_head = slot_at(1);
          shadow_fill--;
        end
      end
      bdq_pkg::ACT_POP_BACK: begin
        if (shadow_fill > 0) shadow_fill--;
      end
      bdq_pkg::ACT_DELETE: begin
        kept  = 0;
        total = shadow_fill;
        for (int unsigned i = 0; i < total; i++) begin
          v = shadow_slots[slot_at(i)];
          if (v != val) begin
            shadow_slots[slot_at(kept)] = v;
            kept++;
          end
        end
        shadow_fill = kept;
      end
      bdq_pkg::ACT_READ_ALL: begin
        is_read = 1'b1;
        queue_reads(0, shadow_fill);
      end
      bdq_pkg::ACT_READ_FIRST: begin
        is_read = 1'b1;
        queue_reads(0, n);
      end
      bdq_pkg::ACT_READ_LAST: begin
        is_read = 1'b1;
        queue_reads(shadow_fill - n, n);
      end
      bdq_pkg::ACT_CLEAR: begin
        shadow_head = 0;
        shadow_fill = 0;
      end
      default: ;
    endcase
    if (!is_read) queue_result(bdq_pkg::KIND_ACK, 32'd0, 1'b1, ovf);
  endfunction

  task automatic send_cmd(logic [3:0] act, logic [31:0] val, logic [5:0] cnt);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action = act;
    in_value  = val;
    in_count  = cnt;
    start     = 1'b1;
    do @(posedge clk); while (busy);
    apply_command(act, val, cnt);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 32'($signed($urandom_range(0, 6)) - 3);
    if (sel < 7 && shadow_fill > 0) return shadow_slots[slot_at($urandom_range(0, shadow_fill - 1))];
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_count();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, shadow_fill));
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: kind %0d value %0d",
               out_kind, out_entry_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind expected %0d actual %0d", want.kind, out_kind);
          mismatch_count++;
        end
        if (out_entry_value !== want.entry_value) begin
          $error("out_entry_value expected %0d actual %0d",
                 $signed(want.entry_value), out_entry_value);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $error("out_last_of_run expected %0d actual %0d", want.last_of_run,
                 out_last_of_run);
          mismatch_count++;
        end
        if (out_length !== want.length) begin
          $error("out_length expected %0d actual %0d", want.length, out_length);
          mismatch_count++;
        end
        if (out_overflow !== want.overflow) begin
          $error("out_overflow expected %0d actual %0d", want.overflow, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(bdq_pkg::ACT_POP_FRONT, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_POP_BACK, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_LAST, 32'd0, 6'd5);
    send_cmd(bdq_pkg::ACT_DELETE, 32'd7, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_BACK, 32'h7fff_ffff, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_FRONT, 32'hffff_ffff, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_BACK, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_BACK, 32'hffff_ffff, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_FIRST, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_FIRST, 32'd0, 6'd2);
    send_cmd(bdq_pkg::ACT_READ_LAST, 32'd0, 6'd63);
    send_cmd(bdq_pkg::ACT_DELETE, 32'h1234_5678, 6'd0);
    send_cmd(bdq_pkg::ACT_DELETE, 32'hffff_ffff, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_POP_FRONT, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_POP_BACK, 32'd0, 6'd0);
    send_cmd(ACT_UNUSED_LO, 32'd0, 6'd0);
    send_cmd(ACT_UNUSED_HI, 32'hffff_ffff, 6'd63);
    send_cmd(bdq_pkg::ACT_READ_LAST, 32'd0, 6'd1);
    send_cmd(bdq_pkg::ACT_CLEAR, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
  endtask

  task automatic test_overflow();
    while (shadow_fill < DEPTH) begin
      send_cmd($urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_FRONT : bdq_pkg::ACT_PUSH_BACK,
               pick_value(), 6'd0);
    end
    send_cmd(bdq_pkg::ACT_PUSH_FRONT, $urandom, 6'd0);
    send_cmd(bdq_pkg::ACT_PUSH_BACK, $urandom, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
    send_cmd(bdq_pkg::ACT_READ_LAST, 32'd0, 6'd63);
    send_cmd(bdq_pkg::ACT_READ_FIRST, 32'd0, 6'd32);
    send_cmd(bdq_pkg::ACT_DELETE, shadow_slots[slot_at(3)], 6'd0);
    send_cmd(bdq_pkg::ACT_READ_ALL, 32'd0, 6'd0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned items);
    int unsigned r;
    logic [3:0]  act;
    for (int unsigned k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (shadow_fill < 3 && r >= 30 && r < 55) r = r - 30;
      if (r < 35)       act = $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_FRONT
                                                   : bdq_pkg::ACT_PUSH_BACK;
      else if (r < 47)  act = $urandom_range(0, 1) ? bdq_pkg::ACT_POP_FRONT
                                                   : bdq_pkg::ACT_POP_BACK;
      else if (r < 57)  act = bdq_pkg::ACT_DELETE;
      else if (r < 64)  act = bdq_pkg::ACT_READ_ALL;
      else if (r < 72)  act = bdq_pkg::ACT_READ_FIRST;
      else if (r < 80)  act = bdq_pkg::ACT_READ_LAST;
      else if (r < 83)  act = bdq_pkg::ACT_CLEAR;
      else if (r < 87)  act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      else              act = bdq_pkg::ACT_PUSH_BACK;
      send_cmd(act, pick_value(), pick_count());
      if (k == items / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = bdq_pkg::ACT_CLEAR;
    in_value       = '0;
    in_count       = '0;
    shadow_head    = 0;
    shadow_fill    = 0;
    mismatch_count = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_overflow();
    test_random(48);

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bounded_deque_with_value_delete_unit] OK");
    end else begin
      $display("[bounded_deque_with_value_delete_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_deque_with_value_delete_unit.sv
tb/testbench.sv
